>>> rtl/core/cfsp_pkg.sv
// Package for the cube face sphere projection core.
// Holds transaction structs, configuration struct, widths and codes.
// No dependencies.
package cfsp_pkg;

   localparam int COORD_W = 32;
   localparam int IDX_W   = 6;
   localparam int FACE_W  = 3;
   localparam int STEP_W  = 31;
   localparam int RAD_W   = 31;
   localparam int OFF_W   = IDX_W + STEP_W;     // index times step
   localparam int AX_W    = OFF_W + 2;          // signed cube coordinate
   localparam int MAG_W   = AX_W - 1;           // coordinate magnitude
   localparam int HALF_W  = (MAG_W + 1) / 2;    // square split point
   localparam int PART_W  = 2 * HALF_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = (SUM_W + 2) / 2;
   localparam int PROD_W  = HALF_W + RAD_W;
   localparam int NUM_W   = MAG_W + RAD_W + 1;
   localparam int Q_W     = RAD_W;
   localparam int CSR_IDX_W = 2;

   // Pipeline depth from accepted request to response strobe.
   localparam int LATENCY = 5 + ROOT_W + 2 + Q_W + 1;

   localparam logic [FACE_W-1:0] FACE_LOW_Z  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_LOW_Y  = 3'd1;
   localparam logic [FACE_W-1:0] FACE_LOW_X  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_HIGH_Z = 3'd3;
   localparam logic [FACE_W-1:0] FACE_HIGH_Y = 3'd4;
   localparam logic [FACE_W-1:0] FACE_HIGH_X = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_STEP = 2'd3;

   localparam logic [RAD_W-1:0]          RADIUS_RST    = 31'd16777216;
   localparam logic signed [COORD_W-1:0] EDGE_LOW_RST  = -32'sd16777048;
   localparam logic signed [COORD_W-1:0] EDGE_HIGH_RST = 32'sd16777048;
   localparam logic [STEP_W-1:0]         EDGE_STEP_RST = 31'd1765998;

   typedef struct packed {
      logic [IDX_W-1:0]  grid_col;
      logic [IDX_W-1:0]  grid_row;
      logic [FACE_W-1:0] face;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_out;
      logic signed [COORD_W-1:0] y_out;
      logic signed [COORD_W-1:0] z_out;
   } rsp_type;

   typedef struct packed {
      logic [RAD_W-1:0]          radius;
      logic signed [COORD_W-1:0] edge_low;
      logic signed [COORD_W-1:0] edge_high;
      logic [STEP_W-1:0]         edge_step;
   } cfg_type;

   // Per-point data that rides alongside the square root.
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
      logic                  kill;
   } side_type;

endpackage

>>> rtl/core/cfsp_point.sv
// Places a grid point on its cube face and forms the sum of squares.
// Five register stages. Depends on cfsp_pkg.
module cfsp_point import cfsp_pkg::*; #(
   parameter int MAX_EDGE_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  req_type          in_req,
   input  cfg_type          cfg,
   output logic             out_valid,
   output logic [SUM_W-1:0] out_sum,
   output side_type         out_side
);

   localparam logic [12:0] IDX_MAX = 13'(MAX_EDGE_POINTS - 1);

   // stage 1: grid offsets
   logic              v1_ff;
   logic [OFF_W-1:0]  jd_ff, kd_ff, jd_in, kd_in;
   logic [FACE_W-1:0] face1_ff;
   logic [IDX_W-1:0]  j_cl, k_cl;

   // stage 2: cube coordinates
   logic                 v2_ff, kill2_ff, kill2_in;
   logic signed [AX_W-1:0] a2_ff [3];
   logic signed [AX_W-1:0] a2_in [3];

   // stage 3: magnitudes and partial squares
   logic             v3_ff, kill3_ff;
   logic [2:0]       neg3_ff, neg3_in;
   logic [MAG_W-1:0] mag3_ff [3];
   logic [MAG_W-1:0] mag3_in [3];
   logic [PART_W-1:0] hh_ff [3], hl_ff [3], ll_ff [3];
   logic [PART_W-1:0] hh_in [3], hl_in [3], ll_in [3];

   // stage 4: squares
   logic             v4_ff;
   side_type         side4_ff, side3;
   logic [SQ_W-1:0]  sq_ff [3];
   logic [SQ_W-1:0]  sq_in [3];

   // stage 5: sum
   logic             v5_ff;
   side_type         side5_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      j_cl  = ({7'b0, in_req.grid_col} > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : in_req.grid_col;
      k_cl  = ({7'b0, in_req.grid_row} > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : in_req.grid_row;
      jd_in = OFF_W'(cfg.edge_step) * OFF_W'(j_cl);
      kd_in = OFF_W'(cfg.edge_step) * OFF_W'(k_cl);
   end

   always_comb begin
      logic signed [AX_W-1:0] lo, hi, jd, kd;
      lo = AX_W'(cfg.edge_low);
      hi = AX_W'(cfg.edge_high);
      jd = signed'({2'b0, jd_ff});
      kd = signed'({2'b0, kd_ff});
      kill2_in = 1'b0;
      unique case (face1_ff)
         FACE_LOW_Z: begin
            a2_in[0] = lo + jd; a2_in[1] = lo + kd; a2_in[2] = lo;
         end
         FACE_LOW_Y: begin
            a2_in[0] = hi - jd; a2_in[1] = lo; a2_in[2] = lo + kd;
         end
         FACE_LOW_X: begin
            a2_in[0] = lo; a2_in[1] = lo + jd; a2_in[2] = lo + kd;
         end
         FACE_HIGH_Z: begin
            a2_in[0] = hi - jd; a2_in[1] = lo + kd; a2_in[2] = hi;
         end
         FACE_HIGH_Y: begin
            a2_in[0] = lo + jd; a2_in[1] = hi; a2_in[2] = lo + kd;
         end
         FACE_HIGH_X: begin
            a2_in[0] = hi; a2_in[1] = hi - jd; a2_in[2] = lo + kd;
         end
         default: begin
            a2_in[0] = '0; a2_in[1] = '0; a2_in[2] = '0;
            kill2_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      logic [AX_W-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m = a2_ff[i][AX_W-1] ? AX_W'(-a2_ff[i]) : AX_W'(a2_ff[i]);
         mag3_in[i] = m[MAG_W-1:0];
         neg3_in[i] = a2_ff[i][AX_W-1];
         hh_in[i] = PART_W'(mag3_in[i][MAG_W-1:HALF_W]) * PART_W'(mag3_in[i][MAG_W-1:HALF_W]);
         hl_in[i] = PART_W'(mag3_in[i][MAG_W-1:HALF_W]) * PART_W'(mag3_in[i][HALF_W-1:0]);
         ll_in[i] = PART_W'(mag3_in[i][HALF_W-1:0]) * PART_W'(mag3_in[i][HALF_W-1:0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'({hh_ff[i], (2 * HALF_W)'(0)})
                  + SQ_W'({hl_ff[i], (HALF_W + 1)'(0)})
                  + SQ_W'(ll_ff[i]);
      end
      side3.neg  = neg3_ff;
      side3.mag  = {mag3_ff[2], mag3_ff[1], mag3_ff[0]};
      side3.kill = kill3_ff;
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      jd_ff    <= jd_in;
      kd_ff    <= kd_in;
      face1_ff <= in_req.face;
      kill2_ff <= kill2_in;
      kill3_ff <= kill2_ff;
      neg3_ff  <= neg3_in;
      for (int i = 0; i < 3; i++) begin
         a2_ff[i]   <= a2_in[i];
         mag3_ff[i] <= mag3_in[i];
         hh_ff[i]   <= hh_in[i];
         hl_ff[i]   <= hl_in[i];
         ll_ff[i]   <= ll_in[i];
         sq_ff[i]   <= sq_in[i];
      end
      side4_ff <= side3;
      side5_ff <= side4_ff;
      sum_ff   <= sum_in;
   end

   assign out_valid = v5_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side5_ff;

endmodule

>>> rtl/core/cfsp_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries the point's side data alongside. Depends on cfsp_pkg.
module cfsp_sqrt import cfsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   localparam int RAD_PAD_W = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 2;

   logic                 v_ff    [ROOT_W];
   logic [RAD_PAD_W-1:0] rad_ff  [ROOT_W];
   logic [REM_W-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]    root_ff [ROOT_W];
   side_type             side_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic                 v_prev;
      logic [RAD_PAD_W-1:0] rad_prev;
      logic [REM_W-1:0]     rem_prev, rem_in;
      logic [ROOT_W-1:0]    root_prev, root_in;
      side_type             side_prev;
      logic [REM_W+1:0]     rem_sh, trial;
      logic                 ge;

      if (g == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rad_prev  = RAD_PAD_W'(in_sum);
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      always_comb begin
         rem_sh  = {rem_prev, rad_prev[RAD_PAD_W-1 -: 2]};
         trial   = (REM_W + 2)'({root_prev, 2'b01});
         ge      = rem_sh >= trial;
         rem_in  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_in = {root_prev[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else begin
            v_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= {rad_prev[RAD_PAD_W-3:0], 2'b00};
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         side_ff[g] <= side_prev;
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

>>> rtl/core/cfsp_scale.sv
// Scales one coordinate magnitude by radius / norm with rounding.
// Two product stages, one quotient bit per stage, then a sign stage. Depends on cfsp_pkg.
module cfsp_scale import cfsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [MAG_W-1:0]          in_mag,
   input  logic                      in_neg,
   input  logic                      in_kill,
   input  logic [ROOT_W-1:0]         in_root,
   input  logic [RAD_W-1:0]          radius,
   output logic                      out_valid,
   output logic signed [COORD_W-1:0] out_coord
);

   // product stages
   logic              p1_v_ff, p1_neg_ff, p1_kill_ff;
   logic [PROD_W-1:0] p_lo_ff, p_hi_ff;
   logic [ROOT_W-1:0] p1_root_ff;
   logic              p2_v_ff, p2_neg_ff, p2_kill_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [ROOT_W-1:0] p2_root_ff;

   // quotient stages
   logic              v_ff    [Q_W];
   logic              neg_ff  [Q_W];
   logic              kill_ff [Q_W];
   logic [NUM_W-1:0]  numq_ff [Q_W];
   logic [ROOT_W-1:0] den_ff  [Q_W];
   logic [ROOT_W-1:0] rem_ff  [Q_W];
   logic [Q_W-1:0]    q_ff    [Q_W];

   logic                      out_v_ff;
   logic signed [COORD_W-1:0] coord_ff, coord_in;

   assign num_in = NUM_W'({p_hi_ff, HALF_W'(0)}) + NUM_W'(p_lo_ff)
                 + NUM_W'(p1_root_ff[ROOT_W-1:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         p1_v_ff  <= in_valid;
         p2_v_ff  <= p1_v_ff;
         out_v_ff <= v_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      p_lo_ff    <= PROD_W'(in_mag[HALF_W-1:0]) * PROD_W'(radius);
      p_hi_ff    <= PROD_W'(in_mag[MAG_W-1:HALF_W]) * PROD_W'(radius);
      p1_root_ff <= in_root;
      p1_neg_ff  <= in_neg;
      p1_kill_ff <= in_kill || (in_root == '0);
      num_ff     <= num_in;
      p2_root_ff <= p1_root_ff;
      p2_neg_ff  <= p1_neg_ff;
      p2_kill_ff <= p1_kill_ff;
      coord_ff   <= coord_in;
   end

   for (genvar g = 0; g < Q_W; g++) begin : g_stage
      logic              v_prev, neg_prev, kill_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [ROOT_W-1:0] den_prev, rem_prev, rem_in;
      logic [Q_W-1:0]    q_prev;
      logic [ROOT_W:0]   rem_sh;
      logic              ge;

      if (g == 0) begin : g_first
         // top bits of the numerator already lie below the norm
         assign v_prev    = p2_v_ff;
         assign neg_prev  = p2_neg_ff;
         assign kill_prev = p2_kill_ff;
         assign num_prev  = num_ff;
         assign den_prev  = p2_root_ff;
         assign rem_prev  = ROOT_W'(num_ff[NUM_W-1:Q_W]);
         assign q_prev    = '0;
      end else begin : g_next
         assign v_prev    = v_ff[g-1];
         assign neg_prev  = neg_ff[g-1];
         assign kill_prev = kill_ff[g-1];
         assign num_prev  = numq_ff[g-1];
         assign den_prev  = den_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign q_prev    = q_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_prev, num_prev[Q_W-1-g]};
         ge     = rem_sh >= {1'b0, den_prev};
         rem_in = ge ? ROOT_W'(rem_sh - {1'b0, den_prev}) : ROOT_W'(rem_sh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else begin
            v_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         neg_ff[g]  <= neg_prev;
         kill_ff[g] <= kill_prev;
         numq_ff[g] <= num_prev;
         den_ff[g]  <= den_prev;
         rem_ff[g]  <= rem_in;
         q_ff[g]    <= {q_prev[Q_W-2:0], ge};
      end
   end

   always_comb begin
      logic signed [COORD_W-1:0] q;
      q = signed'({1'b0, q_ff[Q_W-1]});
      if (kill_ff[Q_W-1]) begin
         coord_in = '0;
      end else if (neg_ff[Q_W-1]) begin
         coord_in = -q;
      end else begin
         coord_in = q;
      end
   end

   assign out_valid = out_v_ff;
   assign out_coord = coord_ff;

endmodule

>>> rtl/core/cube_face_sphere_projection_core.sv
// Top level of the cube face sphere projection core.
// Holds the configuration registers and chains cfsp_point, cfsp_sqrt and cfsp_scale.
// Depends on cfsp_pkg.
//
// Takes one grid point per clock and returns its projection onto the sphere after
// these steps in order: the point is placed and its squares summed, the square root
// pipeline forms the root bit by bit, magnitude times radius is formed, the divide
// forms the quotient bit by bit, and a final stage applies the sign. rsp_valid
// pulses for one cycle per transaction and the receiver cannot stall it; busy is
// high only during reset. Write configuration only while no transaction is in
// flight.
module cube_face_sphere_projection_core import cfsp_pkg::*; #(
   parameter int MAX_EDGE_POINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   cfg_type           cfg_ff;
   logic              pt_valid;
   logic [SUM_W-1:0]  pt_sum;
   side_type          pt_side;
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   logic [2:0]        sc_valid;
   logic signed [COORD_W-1:0] sc_coord [3];

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius    <= RADIUS_RST;
         cfg_ff.edge_low  <= EDGE_LOW_RST;
         cfg_ff.edge_high <= EDGE_HIGH_RST;
         cfg_ff.edge_step <= EDGE_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:    cfg_ff.radius    <= csr_wdata[RAD_W-1:0];
            CSR_EDGE_LOW:  cfg_ff.edge_low  <= signed'(csr_wdata);
            CSR_EDGE_HIGH: cfg_ff.edge_high <= signed'(csr_wdata);
            CSR_EDGE_STEP: cfg_ff.edge_step <= csr_wdata[STEP_W-1:0];
         endcase
      end
   end

   cfsp_point #(
      .MAX_EDGE_POINTS(MAX_EDGE_POINTS)
   ) u_point (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_req   (req_data),
      .cfg      (cfg_ff),
      .out_valid(pt_valid),
      .out_sum  (pt_sum),
      .out_side (pt_side)
   );

   cfsp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pt_valid),
      .in_sum   (pt_sum),
      .in_side  (pt_side),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      cfsp_scale u_scale (
         .clock    (clock),
         .reset    (reset),
         .in_valid (sq_valid),
         .in_mag   (sq_side.mag[i]),
         .in_neg   (sq_side.neg[i]),
         .in_kill  (sq_side.kill),
         .in_root  (sq_root),
         .radius   (cfg_ff.radius),
         .out_valid(sc_valid[i]),
         .out_coord(sc_coord[i])
      );
   end

   assign rsp_valid      = sc_valid[0];
   assign rsp_data.x_out = sc_coord[0];
   assign rsp_data.y_out = sc_coord[1];
   assign rsp_data.z_out = sc_coord[2];

   // every response traces back to a transaction a fixed depth earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching request");

   // the three axis lanes stay in lockstep
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (sc_valid[0] == sc_valid[1]) && (sc_valid[0] == sc_valid[2]))
      else $error("axis lanes out of step");

   // a non-negative projected x never exceeds the radius
   a_within_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.x_out[COORD_W-1] |->
         rsp_data.x_out[COORD_W-2:0] <= cfg_ff.radius)
      else $error("x beyond radius");

   // unused face codes give a zero point
   a_bad_face_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.face > FACE_HIGH_X, LATENCY) |->
         rsp_data == '0)
      else $error("unused face gave nonzero output");

endmodule

>>> verif/cube_face_sphere_projection_core_tb.sv
// Testbench for cube_face_sphere_projection_core: drives grid points under several
// register settings and checks every projection against an in-bench predictor.
// Depends on cfsp_pkg and the core RTL.
`timescale 1ns / 100ps

module cube_face_sphere_projection_core_tb;
   import cfsp_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   cube_face_sphere_projection_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the register file
   logic [RAD_W-1:0]          cur_radius;
   logic signed [COORD_W-1:0] cur_low;
   logic signed [COORD_W-1:0] cur_high;
   logic [STEP_W-1:0]         cur_step;

   req_type pending_q[$];
   rsp_type projection_q[$];
   int      fail_count;
   int      idle_pct;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic signed [COORD_W-1:0] scale_coord(longint v,
                                                             logic [127:0] norm);
      logic [127:0] mag;
      logic [127:0] q;
      logic signed [COORD_W-1:0] res;
      mag = 128'((v < 0) ? -v : v);
      q = (mag * cur_radius + (norm >> 1)) / norm;
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      res = q[COORD_W-1:0];
      return (v < 0) ? -res : res;
   endfunction

   function automatic rsp_type project_point(req_type r);
      longint lo, hi, jd, kd, ax, ay, az;
      logic [127:0] mx, my, mz, sum, root, trial;
      rsp_type res;
      res = '0;
      lo = longint'(cur_low);
      hi = longint'(cur_high);
      jd = longint'({58'd0, r.grid_col}) * longint'({33'd0, cur_step});
      kd = longint'({58'd0, r.grid_row}) * longint'({33'd0, cur_step});
      case (r.face)
         FACE_LOW_Z: begin ax = lo + jd; ay = lo + kd; az = lo; end
         FACE_LOW_Y: begin ax = hi - jd; ay = lo; az = lo + kd; end
         FACE_LOW_X: begin ax = lo; ay = lo + jd; az = lo + kd; end
         FACE_HIGH_Z: begin ax = hi - jd; ay = lo + kd; az = hi; end
         FACE_HIGH_Y: begin ax = lo + jd; ay = hi; az = lo + kd; end
         FACE_HIGH_X: begin ax = hi; ay = hi - jd; az = lo + kd; end
         default: return res;
      endcase
      mx = 128'((ax < 0) ? -ax : ax);
      my = 128'((ay < 0) ? -ay : ay);
      mz = 128'((az < 0) ? -az : az);
      sum = mx * mx + my * my + mz * mz;
      root = '0;
      for (int b = 40; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= sum) root = trial;
      end
      if (root == '0) return res;
      res.x_out = scale_coord(ax, root);
      res.y_out = scale_coord(ay, root);
      res.z_out = scale_coord(az, root);
      return res;
   endfunction

   // driver: start holds until the transaction is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) projection_q.push_back(project_point(req_data));
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pending_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (projection_q.size() == 0) begin
            $error("unexpected transaction x=%0d y=%0d z=%0d",
                   rsp_data.x_out, rsp_data.y_out, rsp_data.z_out);
            fail_count++;
         end else begin
            want = projection_q.pop_front();
            if (rsp_data.x_out !== want.x_out) begin
               $error("x_out expected %0d actual %0d", want.x_out, rsp_data.x_out);
               fail_count++;
            end
            if (rsp_data.y_out !== want.y_out) begin
               $error("y_out expected %0d actual %0d", want.y_out, rsp_data.y_out);
               fail_count++;
            end
            if (rsp_data.z_out !== want.z_out) begin
               $error("z_out expected %0d actual %0d", want.z_out, rsp_data.z_out);
               fail_count++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RADIUS:    cur_radius = val[RAD_W-1:0];
         CSR_EDGE_LOW:  cur_low = val;
         CSR_EDGE_HIGH: cur_high = val;
         CSR_EDGE_STEP: cur_step = val[STEP_W-1:0];
      endcase
   endtask

   task automatic set_config(logic [31:0] rad, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] step);
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_EDGE_LOW, lo);
      write_reg(CSR_EDGE_HIGH, hi);
      write_reg(CSR_EDGE_STEP, step);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every transaction has come back, then let the pipe drain
   task automatic drain();
      while (pending_q.size() > 0 || start || projection_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic req_type random_point();
      req_type r;
      r.grid_col = IDX_W'($urandom_range(63));
      r.grid_row = IDX_W'($urandom_range(63));
      // mostly valid faces, a few unused codes
      r.face = ($urandom_range(19) == 0) ? FACE_W'($urandom_range(7, 6))
                                         : FACE_W'($urandom_range(5));
      return r;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         // no idling for a stretch in the middle of each phase
         idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 24;
         pending_q.push_back(random_point());
         while (pending_q.size() > 4) @(posedge clock);
      end
      drain();
   endtask

   initial begin
      req_type r;
      fail_count = 0;
      idle_pct = 24;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_RADIUS;
      csr_wdata = '0;
      cur_radius = RADIUS_RST;
      cur_low = EDGE_LOW_RST;
      cur_high = EDGE_HIGH_RST;
      cur_step = EDGE_STEP_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners of every face code under reset settings
      for (int f = 0; f < 8; f++) begin
         r.face = FACE_W'(f);
         r.grid_col = '0;          r.grid_row = '0;          pending_q.push_back(r);
         r.grid_col = IDX_W'(63);  r.grid_row = IDX_W'(63);  pending_q.push_back(r);
         if (f < 4) begin
            r.grid_col = IDX_W'(63); r.grid_row = '0; pending_q.push_back(r);
         end
      end
      drain();
      random_phase(150);

      // zero norm: every point collapses to the origin
      set_config(32'd16777216, 32'd0, 32'd0, 32'd0);
      for (int f = 0; f < 6; f++) begin
         r.face = FACE_W'(f);
         r.grid_col = IDX_W'($urandom_range(63));
         r.grid_row = IDX_W'($urandom_range(63));
         pending_q.push_back(r);
      end
      drain();

      // extremes of every register
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_phase(120);
      set_config(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
      random_phase(60);
      set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      random_phase(60);

      for (int p = 0; p < 5; p++) begin
         set_config($urandom, $urandom, $urandom,
                    (p % 2) ? $urandom : ($urandom >> $urandom_range(8, 20)));
         random_phase(120);
      end

      if (fail_count == 0) begin
         $display("cube_face_sphere_projection_core: match");
      end else begin
         $display("cube_face_sphere_projection_core: mismatch");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("cube_face_sphere_projection_core: mismatch");
      $finish;
   end

endmodule
